>>> rtl/assert_macros.svh
// Assertion helpers shared by the list datapath modules.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define PIL_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that, when true, requires another one in the same cycle.
`define PIL_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/pil_pkg.sv
package pil_pkg;

	// Action codes carried in the input beat.
	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_INSERT = 3'd2;
	localparam logic [2:0] ACT_ERASE  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	// Status codes returned in the output beat.
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_EMPTY  = 2'd1;
	localparam logic [1:0] STS_FULL   = 2'd2;
	localparam logic [1:0] STS_BADPOS = 2'd3;

	localparam int TDATA_W = 48;

	// Input beat, action in the lowest bits.
	typedef struct packed {
		logic [5:0]         pad;
		logic signed [31:0] value;
		logic [6:0]         position;
		logic [2:0]         action;
	} pil_in_t;

	// Output beat, status in the lowest bits.
	typedef struct packed {
		logic [6:0]         pad;
		logic [6:0]         count;
		logic signed [31:0] read_value;
		logic [1:0]         status;
	} pil_out_t;

	// Port enables from the sequencer to the entry memory.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} pil_mem_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_DRAIN,
		S_PUT,
		S_READ,
		S_DONE
	} pil_state_t;

endpackage

>>> rtl/pil_ram.sv
module pil_ram import pil_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  pil_mem_ctl_t     ctl,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/pil_seq.sv
`include "assert_macros.svh"

module pil_seq import pil_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int LW = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  pil_in_t               s_in,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output pil_out_t              m_out,
	output pil_mem_ctl_t          mem_ctl,
	output logic [AW-1:0]         mem_wr_addr,
	output logic [DATA_WIDTH-1:0] mem_wr_data,
	output logic [AW-1:0]         mem_rd_addr,
	input  logic [DATA_WIDTH-1:0] mem_rd_data
);

	localparam int CW = (LW > 7) ? LW : 7;

	pil_state_t st_q, st_d;
	logic [LW-1:0] len_q;
	logic [LW-1:0] moves_q;
	logic [AW-1:0] src_q, dst_q, put_q;
	logic down_q, rd_ok_q, need_put_q;
	logic [1:0] status_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic pend_s1;
	logic [AW-1:0] dst_s1;
	logic m_valid_q;
	logic [1:0] out_status_q;
	logic [31:0] out_rdata_q;
	logic [6:0] out_count_q;

	logic accept, load_out;
	logic [CW-1:0] pos_x, len_x;
	logic full, empty;
	pil_state_t dec_next;
	logic [1:0] dec_status;
	logic [LW-1:0] dec_len, dec_moves;
	logic [AW-1:0] dec_src, dec_dst, dec_put;
	logic dec_down, dec_rd_ok, dec_need_put;

	assign s_tready = (st_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign load_out = (st_q == S_DONE) && (!m_valid_q || m_tready);

	assign pos_x = CW'(s_in.position);
	assign len_x = CW'(len_q);
	assign full = (len_q >= LW'(CAPACITY));
	assign empty = (len_q == '0);

	// Decode the incoming beat against the current length.
	always_comb begin
		dec_next = S_DONE;
		dec_status = STS_OK;
		dec_len = len_q;
		dec_moves = '0;
		dec_src = '0;
		dec_dst = '0;
		dec_put = '0;
		dec_down = 1'b0;
		dec_rd_ok = 1'b0;
		dec_need_put = 1'b0;
		unique case (s_in.action)
			ACT_PUSH: begin
				if (full) begin
					dec_status = STS_FULL;
				end else begin
					dec_put = AW'(len_q);
					dec_len = len_q + LW'(1);
					dec_next = S_PUT;
				end
			end
			ACT_POP: begin
				if (empty) begin
					dec_status = STS_EMPTY;
				end else begin
					dec_len = len_q - LW'(1);
				end
			end
			ACT_INSERT: begin
				if (full) begin
					dec_status = STS_FULL;
				end else if (pos_x > len_x) begin
					dec_status = STS_BADPOS;
				end else begin
					dec_moves = LW'(len_x - pos_x);
					dec_src = AW'(len_x - CW'(1));
					dec_dst = AW'(len_q);
					dec_put = AW'(pos_x);
					dec_down = 1'b1;
					dec_need_put = 1'b1;
					dec_len = len_q + LW'(1);
					dec_next = (len_x != pos_x) ? S_MOVE : S_PUT;
				end
			end
			ACT_ERASE: begin
				if (empty) begin
					dec_status = STS_EMPTY;
				end else if (pos_x >= len_x) begin
					dec_status = STS_BADPOS;
				end else begin
					dec_moves = LW'(len_x - pos_x - CW'(1));
					dec_src = AW'(pos_x + CW'(1));
					dec_dst = AW'(pos_x);
					dec_len = len_q - LW'(1);
					dec_next = ((len_x - pos_x) != CW'(1)) ? S_MOVE : S_DONE;
				end
			end
			ACT_READ: begin
				if (empty) begin
					dec_status = STS_EMPTY;
				end else if (pos_x >= len_x) begin
					dec_status = STS_BADPOS;
				end else begin
					dec_src = AW'(pos_x);
					dec_rd_ok = 1'b1;
					dec_next = S_READ;
				end
			end
			default: begin
				dec_status = STS_OK;
			end
		endcase
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE:  st_d = accept ? dec_next : S_IDLE;
			S_MOVE:  st_d = (moves_q == LW'(1)) ? S_DRAIN : S_MOVE;
			S_DRAIN: st_d = need_put_q ? S_PUT : S_DONE;
			S_PUT:   st_d = S_DONE;
			S_READ:  st_d = S_DONE;
			S_DONE:  st_d = load_out ? S_IDLE : S_DONE;
			default: st_d = S_IDLE;
		endcase
	end

	// Memory port control: each shift read is written back in the following cycle.
	always_comb begin
		mem_ctl.rd_en = (st_q == S_MOVE) || (st_q == S_READ);
		mem_ctl.wr_en = pend_s1 || (st_q == S_PUT);
		mem_rd_addr = src_q;
		mem_wr_addr = pend_s1 ? dst_s1 : put_q;
		mem_wr_data = pend_s1 ? mem_rd_data : val_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			len_q <= '0;
			pend_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			pend_s1 <= (st_q == S_MOVE);
			if (accept) begin
				len_q <= dec_len;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Per-item working registers and the shift cursors.
	always_ff @(posedge clk) begin
		dst_s1 <= dst_q;
		if (accept) begin
			status_q <= dec_status;
			moves_q <= dec_moves;
			src_q <= dec_src;
			dst_q <= dec_dst;
			put_q <= dec_put;
			down_q <= dec_down;
			rd_ok_q <= dec_rd_ok;
			need_put_q <= dec_need_put;
			val_q <= DATA_WIDTH'($unsigned(s_in.value));
		end else if (st_q == S_MOVE) begin
			moves_q <= moves_q - LW'(1);
			src_q <= down_q ? src_q - AW'(1) : src_q + AW'(1);
			dst_q <= down_q ? dst_q - AW'(1) : dst_q + AW'(1);
		end
	end

	// Output register holds the result beat while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_rdata_q <= rd_ok_q ? 32'(signed'(mem_rd_data)) : '0;
			out_count_q <= 7'(len_q);
		end
	end

	assign m_tvalid = m_valid_q;
	always_comb begin
		m_out.pad = '0;
		m_out.count = out_count_q;
		m_out.read_value = out_rdata_q;
		m_out.status = out_status_q;
	end

	`PIL_CHECK(a_len_bound, len_q <= LW'(CAPACITY), "length exceeds capacity")
	`PIL_IMPLY(a_rw_apart, mem_ctl.rd_en && mem_ctl.wr_en, mem_rd_addr != mem_wr_addr, "shift read and write hit one entry")
	`PIL_IMPLY(a_put_alone, st_q == S_PUT, !pend_s1, "value write collides with shift write")
	`PIL_IMPLY(a_load_done, $rose(m_valid_q), $past(st_q == S_DONE), "result loaded outside done state")

endmodule

>>> rtl/positional_insert_erase_list.sv
// Positional list: an ordered list of signed values kept in one memory.
// Input channel s_*: one beat asks for push, pop, insert, erase or read.
// Output channel m_*: exactly one result beat per input beat, in order.
// Insert moves the entries from the position on up by one, erase moves
// those behind the position down by one; an insert at the end or an erase
// of the last entry moves none, nor do push, pop, read or failed actions.
// The shift moves one entry per cycle through the memory's single read
// and single write port.
// s_tready is high only while no item is in work; the result then sits in
// an output register, so a new beat is taken while it waits to be sent.
// If m_tready stays low, the following item finishes its work and waits
// until the output register is free.
// Reset empties the list at once; memory contents are not cleared, as no
// entry is read before it has been written.
module positional_insert_erase_list import pil_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // action[2:0], position[9:3], value[41:10]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata   // status[1:0], read_value[33:2], count[40:34]
);

	localparam int AW = $clog2(CAPACITY);

	pil_in_t s_in;
	pil_out_t m_out;
	pil_mem_ctl_t mem_ctl;
	logic [AW-1:0] mem_wr_addr, mem_rd_addr;
	logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

	assign s_in = s_tdata;
	assign m_tdata = m_out;

	// Sequencer: decode, shift control and result register.
	pil_seq #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_in(s_in),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_out(m_out),
		.mem_ctl(mem_ctl),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	// Entry store.
	pil_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk(clk),
		.ctl(mem_ctl),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

endmodule
